// ===== rtl/core/msdb_pkg.sv =====
// ----------------------------------------------------------------------------
// msdb_pkg
// Shared types, constants and the sample coverage function for the 4x MSAA
// sample depth buffer.
// ----------------------------------------------------------------------------
package msdb_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int SAMPLES        = 4;
    localparam int LANE_W         = 32;
    localparam int WORD_W         = SAMPLES * LANE_W;
    localparam int DIM_W          = 13;
    localparam int LIN_W          = 2 * DIM_W;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int COV_W          = 28;

    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 9'd256;

    localparam logic [LANE_W-1:0]       CLEAR_DEPTH = 32'h8000_0000;
    localparam logic [7:0]              CLEAR_ALPHA = 8'hFF;
    localparam logic signed [COV_W-1:0] ONE_EIGHTHS = 28'sd524288;

    typedef logic signed [2:0] ofs_t;
    localparam ofs_t SAMPLE_OX [SAMPLES] = '{3'sd3, -3'sd1, 3'sd1, -3'sd3};
    localparam ofs_t SAMPLE_OY [SAMPLES] = '{3'sd1, 3'sd3, -3'sd3, -3'sd1};

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // exact coverage at the rotated-grid offsets, in units of 2^-19
    function automatic logic [SAMPLES-1:0] coverage(
        input logic signed [20:0] a,
        input logic signed [20:0] b,
        input logic signed [20:0] dadx,
        input logic signed [20:0] dady,
        input logic signed [20:0] dbdx,
        input logic signed [20:0] dbdy
    );
        logic signed [COV_W-1:0] sa;
        logic signed [COV_W-1:0] sb;
        logic signed [COV_W-1:0] sg;
        logic [SAMPLES-1:0]      cov;
        for (int i = 0; i < SAMPLES; i++)
        begin
            sa = (COV_W'(a) <<< 3) + COV_W'(SAMPLE_OX[i]) * COV_W'(dadx)
               + COV_W'(SAMPLE_OY[i]) * COV_W'(dady);
            sb = (COV_W'(b) <<< 3) + COV_W'(SAMPLE_OX[i]) * COV_W'(dbdx)
               + COV_W'(SAMPLE_OY[i]) * COV_W'(dbdy);
            sg = ONE_EIGHTHS - sa - sb;
            cov[i] = !sa[COV_W-1] && !sb[COV_W-1] && !sg[COV_W-1];
        end
        return cov;
    endfunction

endpackage

// ===== rtl/core/msdb_if.sv =====
// ----------------------------------------------------------------------------
// msdb_if
// Request and response channels of the sample depth buffer.
// ----------------------------------------------------------------------------
interface msdb_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [10:0] pixel_x;
    logic signed [10:0] pixel_y;
    logic signed [31:0] depth;
    logic [31:0]        color_rgba;
    logic signed [20:0] bary_a;
    logic signed [20:0] bary_b;
    logic signed [20:0] da_dx;
    logic signed [20:0] da_dy;
    logic signed [20:0] db_dx;
    logic signed [20:0] db_dy;

    modport source (
        output valid, req_type, pixel_x, pixel_y, depth, color_rgba,
               bary_a, bary_b, da_dx, da_dy, db_dx, db_dy,
        input  ready
    );
    modport sink (
        input  valid, req_type, pixel_x, pixel_y, depth, color_rgba,
               bary_a, bary_b, da_dx, da_dy, db_dx, db_dy,
        output ready
    );
endinterface

interface msdb_rsp_if;
    logic       valid;
    logic       ready;
    logic       in_bounds;
    logic       visible;
    logic [3:0] written_mask;

    modport source (
        output valid, in_bounds, visible, written_mask,
        input  ready
    );
    modport sink (
        input  valid, in_bounds, visible, written_mask,
        output ready
    );
endinterface

// ===== rtl/core/msaa_sample_depth_buffer.sv =====
// ----------------------------------------------------------------------------
// msaa_sample_depth_buffer
// 4x rotated-grid MSAA back end: coverage, depth test and sample store.
// ----------------------------------------------------------------------------
// Draw and query: the stage-1 registers, then the output registers hold the result; one transfer
// per cycle while the output is not stalled; depth word read-modify-write with a one-entry bypass.
// Clear: sweeps every pixel word of the store, one pixel word per cycle of sweep.
// Reset clears control state; width and height registers reset to 256.
// Sample store contents are undefined until the first clear.
module msaa_sample_depth_buffer #(
    parameter int MAX_WIDTH  = msdb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = msdb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [msdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msdb_pkg::CFG_W-1:0]     cfg_wdata,
    msdb_req_if.sink                       req,
    msdb_rsp_if.source                     rsp
);

    localparam int PIX    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int SMP    = msdb_pkg::SAMPLES;
    localparam int LW     = msdb_pkg::LANE_W;
    localparam int WW     = msdb_pkg::WORD_W;
    localparam int DW     = msdb_pkg::DIM_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX - 1);

    // configuration
    logic [msdb_pkg::CFG_W-1:0] width_reg;
    logic [msdb_pkg::CFG_W-1:0] height_reg;

    // stage 1
    logic                     s1_valid_reg;
    logic [1:0]               s1_req_reg;
    logic                     s1_inb_reg;
    logic signed [LW-1:0]     s1_depth_reg;
    logic [LW-1:0]            s1_color_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic [SMP-1:0]           s1_cov_reg;
    logic [WW-1:0]            rdata_reg;

    // bypass of the last written depth word
    logic                     byp_valid_reg;
    logic [ADDR_W-1:0]        byp_addr_reg;
    logic [WW-1:0]            byp_data_reg;

    // output
    logic                     out_valid_reg;
    logic                     out_inb_reg;
    logic                     out_vis_reg;
    logic [SMP-1:0]           out_mask_reg;

    msdb_pkg::state_t         state_reg;
    msdb_pkg::state_t         state_next;
    logic [ADDR_W-1:0]        sweep_cnt_reg;
    logic [ADDR_W-1:0]        sweep_cnt_next;

    // memories
    logic [WW-1:0]            depth_mem [PIX];
    logic [WW-1:0]            color_mem [PIX];

    logic [DW-1:0]            w_lim;
    logic [DW-1:0]            h_lim;
    logic [DW-1:0]            x_u;
    logic [DW-1:0]            y_u;
    logic [msdb_pkg::LIN_W-1:0] lin_addr;
    logic                     s0_inb;
    logic [ADDR_W-1:0]        s0_addr;
    logic [SMP-1:0]           s0_cov;
    logic                     s0_acc;

    logic                     out_free;
    logic                     s1_adv;
    logic [WW-1:0]            eff_word;
    logic [WW-1:0]            new_word;
    logic signed [LW-1:0]     lane_depth [SMP];
    logic [SMP-1:0]           pass;
    logic [SMP-1:0]           nearer;
    logic [SMP-1:0]           s1_mask;
    logic                     s1_vis;
    logic                     draw_we;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [WW-1:0]            depth_wdata;
    logic [LW-1:0]            color_wdata;
    logic [SMP-1:0]           color_lane_we;

    // ---------------- stage 0: bounds, address, coverage ----------------
    always_comb
    begin
        w_lim = (DW'(width_reg) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_reg);
        h_lim = (DW'(height_reg) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(height_reg);
        x_u = DW'(req.pixel_x[9:0]);
        y_u = DW'(req.pixel_y[9:0]);
        s0_inb = !req.pixel_x[10] && (x_u < w_lim) && !req.pixel_y[10] && (y_u < h_lim);
        lin_addr = msdb_pkg::LIN_W'(y_u) * msdb_pkg::LIN_W'(MAX_WIDTH)
                 + msdb_pkg::LIN_W'(x_u);
        s0_addr = s0_inb ? ADDR_W'(lin_addr) : '0;
        s0_cov = msdb_pkg::coverage(req.bary_a, req.bary_b, req.da_dx, req.da_dy,
                                    req.db_dx, req.db_dy);
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_free &&
                       (s1_req_reg != msdb_pkg::REQ_CLEAR || state_reg == msdb_pkg::ST_DONE);
    assign req.ready = (state_reg != msdb_pkg::ST_SWEEP) && (!s1_valid_reg || s1_adv);
    assign s0_acc    = req.valid && req.ready;

    // ---------------- stage 1: depth test and merge ----------------
    always_comb
    begin
        eff_word = (byp_valid_reg && byp_addr_reg == s1_addr_reg) ? byp_data_reg : rdata_reg;
        for (int i = 0; i < SMP; i++)
        begin
            lane_depth[i] = signed'(eff_word[i*LW +: LW]);
            pass[i]       = s1_depth_reg >= lane_depth[i];
            nearer[i]     = s1_depth_reg > lane_depth[i];
        end
        s1_mask = (s1_req_reg == msdb_pkg::REQ_DRAW && s1_inb_reg) ? (s1_cov_reg & pass) : '0;
        s1_vis  = (s1_req_reg == msdb_pkg::REQ_QUERY) && s1_inb_reg && (|nearer);
        for (int i = 0; i < SMP; i++)
        begin
            new_word[i*LW +: LW] = s1_mask[i] ? s1_depth_reg : eff_word[i*LW +: LW];
        end
        draw_we = s1_adv && (s1_req_reg == msdb_pkg::REQ_DRAW) && s1_inb_reg;
    end

    // write port: clear sweep or draw write-back
    always_comb
    begin
        if (state_reg == msdb_pkg::ST_SWEEP)
        begin
            mem_we        = 1'b1;
            mem_addr      = sweep_cnt_reg;
            depth_wdata   = {SMP{msdb_pkg::CLEAR_DEPTH}};
            color_wdata   = {s1_color_reg[23:0], msdb_pkg::CLEAR_ALPHA};
            color_lane_we = '1;
        end
        else
        begin
            mem_we        = draw_we;
            mem_addr      = s1_addr_reg;
            depth_wdata   = new_word;
            color_wdata   = s1_color_reg;
            color_lane_we = draw_we ? s1_mask : '0;
        end
    end

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        case (state_reg)
            msdb_pkg::ST_RUN:
            begin
                sweep_cnt_next = '0;
                if (s1_valid_reg && s1_req_reg == msdb_pkg::REQ_CLEAR)
                begin
                    state_next = msdb_pkg::ST_SWEEP;
                end
            end
            msdb_pkg::ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == LAST_ADDR)
                begin
                    state_next = msdb_pkg::ST_DONE;
                end
            end
            msdb_pkg::ST_DONE:
            begin
                if (s1_adv)
                begin
                    state_next = msdb_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = msdb_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msdb_pkg::ST_RUN;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= msdb_pkg::CFG_DIM_RESET;
            height_reg <= msdb_pkg::CFG_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msdb_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                msdb_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (state_reg == msdb_pkg::ST_SWEEP)
            begin
                byp_valid_reg <= 1'b0;
            end
            else if (draw_we)
            begin
                byp_valid_reg <= 1'b1;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (s0_acc)
        begin
            s1_req_reg   <= req.req_type;
            s1_inb_reg   <= s0_inb;
            s1_depth_reg <= req.depth;
            s1_color_reg <= req.color_rgba;
            s1_addr_reg  <= s0_addr;
            s1_cov_reg   <= s0_cov;
        end
        if (draw_we)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= new_word;
        end
        if (s1_adv)
        begin
            out_inb_reg  <= s1_inb_reg;
            out_vis_reg  <= s1_vis;
            out_mask_reg <= s1_mask;
        end
    end

    // ---------------- sample store ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_addr] <= depth_wdata;
        end
        if (s0_acc)
        begin
            rdata_reg <= depth_mem[s0_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SMP; i++)
        begin
            if (color_lane_we[i])
            begin
                color_mem[mem_addr][i*LW +: LW] <= color_wdata;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.in_bounds    = out_inb_reg;
    assign rsp.visible      = out_vis_reg;
    assign rsp.written_mask = out_mask_reg;

`ifndef SYNTHESIS
    a_no_transfer_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == msdb_pkg::ST_SWEEP |-> !req.ready)
        else $error("request transfer during clear sweep");

    a_sweep_covers_store: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == msdb_pkg::ST_DONE) |-> $past(sweep_cnt_reg) == LAST_ADDR)
        else $error("clear sweep ended before last pixel");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_req_reg == msdb_pkg::REQ_CLEAR && state_reg == msdb_pkg::ST_RUN
        |=> state_reg == msdb_pkg::ST_SWEEP)
        else $error("clear did not start sweep");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.written_mask != '0 |-> rsp.in_bounds && !rsp.visible)
        else $error("written mask without in-bounds draw");
`endif

endmodule
